>>> design/rgb_to_hsv_pixel_converter_macros.svh
// Assertion macros for the RGB to HSV pixel converter.
// Included by the top level; no other dependencies.
`ifndef RGB_TO_HSV_PIXEL_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_PIXEL_CONVERTER_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define RHC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define RHC_ASSERT_SAME(label, clk, rstn, ante, cons)
`define RHC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> design/rhc_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies.
package rhc_pkg;

    // Number of divider cells: one quotient bit per cell.
    localparam int NUM_CELLS = 8;
    localparam int HUE_W     = 17;
    localparam int SAT_W     = 16;

    // Which channel holds the maximum.
    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_t;

    // Data handed from cell to cell along the divider chain.
    typedef struct packed {
        logic             grey;
        logic [7:0]       brightness;
        logic [HUE_W-1:0] hue_rem;
        logic [HUE_W-1:0] hue_div;
        logic [7:0]       hue_q;
        logic [SAT_W-1:0] sat_rem;
        logic [SAT_W-1:0] sat_div;
        logic [7:0]       sat_q;
    } div_t;

endpackage

>>> design/rhc_prep.sv
// Two pipeline stages ahead of the divider chain: extremes, then numerators.
// Depends on rhc_pkg.
module rhc_prep
    import rhc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  pixel_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output div_t   out_data
);

    typedef struct packed {
        logic [7:0]        hi;
        logic [7:0]        d;
        logic [1:0]        sect;
        logic signed [8:0] diff;
    } ext_t;

    logic a_valid_reg, a_valid_next;
    ext_t a_data_reg, a_data_next;
    logic b_valid_reg, b_valid_next;
    div_t b_data_reg, b_data_next;
    logic a_ready, b_ready;

    logic [7:0] hi, lo;
    logic signed [18:0] off, prod, sum, wrapped;
    logic [18:0] d_ext;

    // Each stage takes a new request when empty or when its content moves on.
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Stage one: largest and smallest channel, sector and channel difference.
    always_comb begin
        hi = (in_data.red > in_data.green) ? in_data.red : in_data.green;
        hi = (hi > in_data.blue) ? hi : in_data.blue;
        lo = (in_data.red < in_data.green) ? in_data.red : in_data.green;
        lo = (lo < in_data.blue) ? lo : in_data.blue;
        a_data_next.hi = hi;
        a_data_next.d  = hi - lo;
        if (hi == in_data.red) begin
            a_data_next.sect = SECT_RED;
            a_data_next.diff = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
        end else if (hi == in_data.green) begin
            a_data_next.sect = SECT_GREEN;
            a_data_next.diff = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
        end else begin
            a_data_next.sect = SECT_BLUE;
            a_data_next.diff = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
        end
        a_valid_next = a_ready ? in_valid : a_valid_reg;
    end

    // Stage two: hue numerator wrapped to be non-negative, saturation numerator.
    always_comb begin
        d_ext = {11'd0, a_data_reg.d};
        case (a_data_reg.sect)
            SECT_RED:   off = 19'sd0;
            SECT_GREEN: off = $signed(d_ext) * 19'sd120;
            SECT_BLUE:  off = $signed(d_ext) * 19'sd240;
            default:    off = 19'sd0;
        endcase
        prod    = $signed({{10{a_data_reg.diff[8]}}, a_data_reg.diff}) * 19'sd60;
        sum     = off + prod;
        wrapped = (sum < 19'sd0) ? (sum + $signed(d_ext) * 19'sd360) : sum;

        b_data_next.grey       = (a_data_reg.d == 8'd0);
        b_data_next.brightness = a_data_reg.hi;
        b_data_next.hue_rem    = wrapped[HUE_W-1:0];
        b_data_next.hue_div    = {1'b0, a_data_reg.d, 8'd0};
        b_data_next.hue_q      = 8'd0;
        b_data_next.sat_rem    = {a_data_reg.d, 8'd0} - {8'd0, a_data_reg.d};
        b_data_next.sat_div    = {1'b0, a_data_reg.hi, 7'd0};
        b_data_next.sat_q      = 8'd0;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_data_reg <= a_data_next;
        end
        if (b_ready) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

>>> design/rhc_div_cell.sv
// One cell of the divider chain: one restoring step for hue and saturation.
// Depends on rhc_pkg.
module rhc_div_cell
    import rhc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    logic valid_reg, valid_next;
    div_t data_reg, data_next;
    logic hue_ge, sat_ge;

    assign in_ready = !valid_reg || out_ready;

    // Subtract the shifted divisor where it fits and shift in the quotient bit.
    always_comb begin
        hue_ge    = (in_data.hue_rem >= in_data.hue_div);
        sat_ge    = (in_data.sat_rem >= in_data.sat_div);
        data_next = in_data;
        data_next.hue_rem = hue_ge ? (in_data.hue_rem - in_data.hue_div) : in_data.hue_rem;
        data_next.hue_div = in_data.hue_div >> 1;
        data_next.hue_q   = {in_data.hue_q[6:0], hue_ge};
        data_next.sat_rem = sat_ge ? (in_data.sat_rem - in_data.sat_div) : in_data.sat_rem;
        data_next.sat_div = in_data.sat_div >> 1;
        data_next.sat_q   = {in_data.sat_q[6:0], sat_ge};
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> design/rgb_to_hsv_pixel_converter.sv
// RGB to HSV pixel converter: a request passes the prep stages, the divider cells and the output register.
// Throughput one pixel per clock while m_ready does not stall; set by the chain of eight divider cells,
// each producing one quotient bit of hue and saturation.
// Every stage holds its request under back-pressure and fills bubbles independently.
// Reset (aresetn, synchronous, active low) empties all stages; no clearing pass.
// Depends on rhc_pkg, rhc_prep, rhc_div_cell and the assertion macro header.
`include "rgb_to_hsv_pixel_converter_macros.svh"
module rgb_to_hsv_pixel_converter
    import rhc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  pixel_t s_payload,
    output logic   m_valid,
    input  logic   m_ready,
    output hsv_t   m_payload
);

    logic cell_valid [0:NUM_CELLS];
    logic cell_ready [0:NUM_CELLS];
    div_t cell_data  [0:NUM_CELLS];

    logic m_valid_reg, m_valid_next;
    hsv_t m_payload_reg, m_payload_next;
    logic out_ready;

    // Extremes and numerators.
    rhc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_payload),
        .out_valid (cell_valid[0]),
        .out_ready (cell_ready[0]),
        .out_data  (cell_data[0])
    );

    // Divider chain, most significant quotient bit first.
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        rhc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    // Output register; grey and black pixels give zero hue and saturation.
    assign out_ready              = !m_valid_reg || m_ready;
    assign cell_ready[NUM_CELLS]  = out_ready;

    always_comb begin
        m_payload_next.hue        = cell_data[NUM_CELLS].grey ? 8'd0 : cell_data[NUM_CELLS].hue_q;
        m_payload_next.saturation = cell_data[NUM_CELLS].grey ? 8'd0 : cell_data[NUM_CELLS].sat_q;
        m_payload_next.brightness = cell_data[NUM_CELLS].brightness;
        m_valid_next = out_ready ? cell_valid[NUM_CELLS] : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Hue never leaves its half-degree range.
    `RHC_ASSERT_SAME(a_hue_range, aclk, aresetn, m_valid, m_payload.hue <= 8'd179)
    // A black pixel gives zero hue and zero saturation.
    `RHC_ASSERT_SAME(a_black, aclk, aresetn, m_valid && (m_payload.brightness == 8'd0), (m_payload.hue == 8'd0) && (m_payload.saturation == 8'd0))
    // The last cell holds its request while the output register is blocked.
    `RHC_ASSERT_NEXT(a_chain_hold, aclk, aresetn, cell_valid[NUM_CELLS] && !out_ready, cell_valid[NUM_CELLS] && $stable(cell_data[NUM_CELLS]))

endmodule
